// ===== sv/mft_pkg.sv =====
// ----------------------------------------------------------------------------
// mft_pkg
// Shared types and constants for the multi-turn motor feedback tracker.
// ----------------------------------------------------------------------------
package mft_pkg;

    // Shared multiplier: signed operands and product
    localparam int OPND_W = 33;
    localparam int PROD_W = 2 * OPND_W;

    // Datapath operation codes, one per step of the sequence
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_MAG  = 3'd1;
    localparam logic [2:0] OP_POW  = 3'd2;
    localparam logic [2:0] OP_FLT  = 3'd3;
    localparam logic [2:0] OP_CUR  = 3'd4;
    localparam logic [2:0] OP_TOT  = 3'd5;
    localparam logic [2:0] OP_FIN  = 3'd6;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_INIT_FRAMES = 2'd0;
    localparam logic [1:0] REG_LPF_ALPHA   = 2'd1;
    localparam logic [1:0] REG_POWER_COEF  = 2'd2;

    localparam logic [7:0]  INIT_FRAMES_RST = 8'd50;
    localparam logic [15:0] LPF_ALPHA_RST   = 16'd1966;
    localparam logic [31:0] POWER_COEF_RST  = 32'd16924;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [2:0] op;
        logic       emit;
    } mft_cmd_t;

    typedef struct packed {
        logic init_done;
        logic out_free;
    } mft_stat_t;

endpackage

// ===== sv/motor_feedback_multiturn_tracker.sv =====
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_tracker
// Offset capture, multi-turn angle unwrap, current low-pass and power
// estimate for one decoded motor feedback frame, with an APB register port.
// ----------------------------------------------------------------------------
// Frames are taken one at a time: a new frame is accepted only once the
// previous result has been handed to the output register. Tracked frames
// make five passes through the single shared 33x33 multiplier; offset-capture
// frames skip them.
// Reset: tracker state clears to zero, registers take their defaults.
module motor_feedback_multiturn_tracker #(
    parameter int COUNTS_PER_TURN = 8192
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        angle_raw,
    input  logic signed [15:0] speed_raw,
    input  logic signed [15:0] current_raw,
    input  logic [7:0]         temperature_raw,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               tracking,
    output logic [15:0]        offset_out,
    output logic [15:0]        angle_out,
    output logic signed [15:0] speed_out,
    output logic signed [15:0] current_out,
    output logic [7:0]         temperature_out,
    output logic signed [23:0] turn_count,
    output logic signed [36:0] total_angle_out,
    output logic signed [31:0] filtered_current_q16,
    output logic [28:0]        power_q16
);
    import mft_pkg::*;

    logic [7:0]  init_frames_reg;
    logic [15:0] lpf_alpha_reg;
    logic [31:0] power_coef_reg;
    logic        wr_en;

    mft_cmd_t  cmd;
    mft_stat_t stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_frames_reg <= INIT_FRAMES_RST;
            lpf_alpha_reg   <= LPF_ALPHA_RST;
            power_coef_reg  <= POWER_COEF_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_INIT_FRAMES: init_frames_reg <= pwdata[7:0];
                REG_LPF_ALPHA:   lpf_alpha_reg   <= pwdata[15:0];
                REG_POWER_COEF:  power_coef_reg  <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_INIT_FRAMES: prdata = {24'd0, init_frames_reg};
            REG_LPF_ALPHA:   prdata = {16'd0, lpf_alpha_reg};
            REG_POWER_COEF:  prdata = power_coef_reg;
            default:         prdata = '0;
        endcase
    end

    mft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mft_datapath #(
        .COUNTS_PER_TURN (COUNTS_PER_TURN)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .stat                 (stat),
        .init_frames          (init_frames_reg),
        .lpf_alpha_q16        (lpf_alpha_reg),
        .power_coef_q32       (power_coef_reg),
        .angle_raw            (angle_raw),
        .speed_raw            (speed_raw),
        .current_raw          (current_raw),
        .temperature_raw      (temperature_raw),
        .out_ready            (out_ready),
        .out_valid            (out_valid),
        .tracking             (tracking),
        .offset_out           (offset_out),
        .angle_out            (angle_out),
        .speed_out            (speed_out),
        .current_out          (current_out),
        .temperature_out      (temperature_out),
        .turn_count           (turn_count),
        .total_angle_out      (total_angle_out),
        .filtered_current_q16 (filtered_current_q16),
        .power_q16            (power_q16)
    );

endmodule

// ===== sv/mft_ctrl.sv =====
// ----------------------------------------------------------------------------
// mft_ctrl
// Sequencer: accepts one frame, steps a tracked frame through the shared
// multiplier passes and hands the result to the output register.
// ----------------------------------------------------------------------------
module mft_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mft_pkg::mft_stat_t  stat,
    output mft_pkg::mft_cmd_t   cmd
);
    import mft_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_STEP = 4'd1;
    localparam logic [3:0] S_MAG  = 4'd2;
    localparam logic [3:0] S_POW  = 4'd3;
    localparam logic [3:0] S_FLT  = 4'd4;
    localparam logic [3:0] S_CUR  = 4'd5;
    localparam logic [3:0] S_TOT  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                // capture frames skip the arithmetic
                state_next = stat.init_done ? S_MAG : S_DONE;
            end
            S_MAG:
            begin
                cmd.op     = OP_MAG;
                state_next = S_POW;
            end
            S_POW:
            begin
                cmd.op     = OP_POW;
                state_next = S_FLT;
            end
            S_FLT:
            begin
                cmd.op     = OP_FLT;
                state_next = S_CUR;
            end
            S_CUR:
            begin
                cmd.op     = OP_CUR;
                state_next = S_TOT;
            end
            S_TOT:
            begin
                cmd.op     = OP_TOT;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op     = OP_FIN;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== sv/mft_datapath.sv =====
// ----------------------------------------------------------------------------
// mft_datapath
// Frame registers, tracker state, shared 33x33 multiplier, saturation logic
// and the output register.
// ----------------------------------------------------------------------------
module mft_datapath #(
    parameter int COUNTS_PER_TURN = 8192
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mft_pkg::mft_cmd_t   cmd,
    output mft_pkg::mft_stat_t  stat,
    input  logic [7:0]          init_frames,
    input  logic [15:0]         lpf_alpha_q16,
    input  logic [31:0]         power_coef_q32,
    input  logic [15:0]         angle_raw,
    input  logic signed [15:0]  speed_raw,
    input  logic signed [15:0]  current_raw,
    input  logic [7:0]          temperature_raw,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                tracking,
    output logic [15:0]         offset_out,
    output logic [15:0]         angle_out,
    output logic signed [15:0]  speed_out,
    output logic signed [15:0]  current_out,
    output logic [7:0]          temperature_out,
    output logic signed [23:0]  turn_count,
    output logic signed [36:0]  total_angle_out,
    output logic signed [31:0]  filtered_current_q16,
    output logic [28:0]         power_q16
);
    import mft_pkg::*;

    localparam logic signed [17:0] HALF_TURN     = 18'(COUNTS_PER_TURN / 2);
    localparam logic signed [17:0] NEG_HALF_TURN = -HALF_TURN;
    localparam logic [OPND_W-1:0]  TURN_MULT     = OPND_W'(COUNTS_PER_TURN);
    localparam logic signed [23:0] TURNS_MAX     = 24'sh7F_FFFF;
    localparam logic signed [23:0] TURNS_MIN     = 24'sh80_0000;

    // frame registers
    logic [15:0]        ang_reg;
    logic signed [15:0] spd_reg;
    logic signed [15:0] cur_reg;
    logic [7:0]         tmp_reg;

    // tracker state
    logic               init_done_reg, init_done_next;
    logic [7:0]         init_cnt_reg, init_cnt_next;
    logic [15:0]        offset_reg, offset_next;
    logic [15:0]        prev_reg, prev_next;
    logic signed [23:0] turns_reg, turns_next;
    logic signed [31:0] filter_reg, filter_next;
    logic               out_valid_reg, out_valid_next;

    // work registers
    logic                      trk_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  acc_reg;
    logic [28:0]               power_reg;
    logic signed [36:0]        total_reg;

    logic [8:0]                cnt_inc;
    logic signed [17:0]        diff;
    logic signed [OPND_W-1:0]  mul_a;
    logic signed [OPND_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic [31:0]               cs_low;
    logic [31:0]               cs_abs;
    logic signed [PROD_W-1:0]  flt_sum;
    logic signed [PROD_W-1:0]  flt_shr;
    logic signed [31:0]        flt_sat;
    logic [28:0]               pw_sat;
    logic signed [PROD_W-1:0]  tot_sum;
    logic signed [36:0]        tot_sat;

    assign cnt_inc = {1'b0, init_cnt_reg} + 9'd1;
    assign diff    = $signed({2'b00, ang_reg}) - $signed({2'b00, prev_reg});

    // magnitude of current times speed, fits in 31 bits
    assign cs_low = prod_reg[31:0];
    assign cs_abs = cs_low[31] ? 32'(~cs_low + 32'd1) : cs_low;

    always_comb
    begin
        case (cmd.op)
            OP_MAG:
            begin
                mul_a = {{(OPND_W-16){cur_reg[15]}}, cur_reg};
                mul_b = {{(OPND_W-16){spd_reg[15]}}, spd_reg};
            end
            OP_POW:
            begin
                mul_a = {2'b00, cs_abs[30:0]};
                mul_b = {1'b0, power_coef_q32};
            end
            OP_FLT:
            begin
                mul_a = {filter_reg[31], filter_reg};
                mul_b = {16'd0, 17'(17'd65536 - {1'b0, lpf_alpha_q16})};
            end
            OP_CUR:
            begin
                mul_a = {{(OPND_W-16){cur_reg[15]}}, cur_reg};
                mul_b = {17'd0, lpf_alpha_q16};
            end
            OP_TOT:
            begin
                mul_a = {{(OPND_W-24){turns_reg[23]}}, turns_reg};
                mul_b = TURN_MULT;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // filter: floor((F*(2^16-a) + cur*a*2^16) / 2^16), saturated to 32 bits
    assign flt_sum = acc_reg + (prod_reg <<< 16);
    assign flt_shr = flt_sum >>> 16;
    always_comb
    begin
        if (flt_shr[PROD_W-1:31] != {(PROD_W-31){flt_shr[31]}})
        begin
            flt_sat = flt_shr[PROD_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            flt_sat = flt_shr[31:0];
        end
    end

    // power is never negative; clip to 29 bits
    assign pw_sat = (|prod_reg[PROD_W-1:45]) ? '1 : prod_reg[44:16];

    assign tot_sum = prod_reg + $signed({{(PROD_W-16){1'b0}}, ang_reg});
    always_comb
    begin
        if (tot_sum[PROD_W-1:36] != {(PROD_W-36){tot_sum[36]}})
        begin
            tot_sat = tot_sum[PROD_W-1] ? 37'sh10_0000_0000 : 37'sh0F_FFFF_FFFF;
        end
        else
        begin
            tot_sat = tot_sum[36:0];
        end
    end

    always_comb
    begin
        init_done_next = init_done_reg;
        init_cnt_next  = init_cnt_reg;
        offset_next    = offset_reg;
        prev_next      = prev_reg;
        turns_next     = turns_reg;
        filter_next    = filter_reg;
        if (cmd.step)
        begin
            if (!init_done_reg)
            begin
                if (cnt_inc > {1'b0, init_frames})
                begin
                    init_done_next = 1'b1;
                end
                else
                begin
                    offset_next = ang_reg;
                end
                init_cnt_next = cnt_inc[8] ? 8'hFF : cnt_inc[7:0];
                prev_next     = offset_next;
            end
            else
            begin
                // a jump of more than half a turn is a wrap
                if (diff > HALF_TURN)
                begin
                    if (turns_reg != TURNS_MIN)
                    begin
                        turns_next = turns_reg - 24'sd1;
                    end
                end
                else if (diff < NEG_HALF_TURN)
                begin
                    if (turns_reg != TURNS_MAX)
                    begin
                        turns_next = turns_reg + 24'sd1;
                    end
                end
                prev_next = ang_reg;
            end
        end
        if (cmd.op == OP_TOT)
        begin
            filter_next = flt_sat;
        end
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_done_reg <= 1'b0;
            init_cnt_reg  <= '0;
            offset_reg    <= '0;
            prev_reg      <= '0;
            turns_reg     <= '0;
            filter_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            init_done_reg <= init_done_next;
            init_cnt_reg  <= init_cnt_next;
            offset_reg    <= offset_next;
            prev_reg      <= prev_next;
            turns_reg     <= turns_next;
            filter_reg    <= filter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ang_reg <= angle_raw;
            spd_reg <= speed_raw;
            cur_reg <= current_raw;
            tmp_reg <= temperature_raw;
        end
        if (cmd.step)
        begin
            trk_reg <= init_done_reg;
        end
        if (cmd.op != OP_NONE)
        begin
            prod_reg <= prod_next;
        end
        case (cmd.op)
            OP_FLT:  power_reg <= pw_sat;
            OP_CUR:  acc_reg   <= prod_reg;
            OP_FIN:  total_reg <= tot_sat;
            default: ;
        endcase
        if (cmd.emit)
        begin
            tracking             <= trk_reg;
            offset_out           <= offset_reg;
            angle_out            <= ang_reg;
            speed_out            <= spd_reg;
            current_out          <= cur_reg;
            temperature_out      <= tmp_reg;
            turn_count           <= turns_reg;
            total_angle_out      <= trk_reg ? total_reg : '0;
            filtered_current_q16 <= filter_reg;
            power_q16            <= trk_reg ? power_reg : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign stat.init_done = init_done_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

// ===== sv/mft_checker.sv =====
// ----------------------------------------------------------------------------
// mft_checker
// Port-level checks for the multi-turn tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mft_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               tracking,
    input logic signed [36:0] total_angle_out,
    input logic [28:0]        power_q16
);

    // a result waiting for its transfer stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    // one frame at a time: in_ready stays low through the step state and the state after it
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("frame taken while previous one in progress");

    // capture frames carry no total angle
    a_untracked_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tracking |-> total_angle_out == 37'sd0)
        else $error("nonzero total angle on capture frame");

    // capture frames carry no power
    a_untracked_power: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tracking |-> power_q16 == 29'd0)
        else $error("nonzero power on capture frame");

endmodule

bind motor_feedback_multiturn_tracker mft_checker u_mft_checker (.*);

// ===== test/motor_feedback_multiturn_tracker_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_tracker_check
// Watches the register port and both frame channels of the tracker. It keeps
// its own copy of the tracker state, computes the result of each frame it
// sees transferred in, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_tracker_check #(
    parameter int COUNTS_PER_TURN = 8192
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [15:0]        angle_raw,
    input  logic signed [15:0] speed_raw,
    input  logic signed [15:0] current_raw,
    input  logic [7:0]         temperature_raw,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               tracking,
    input  logic [15:0]        offset_out,
    input  logic [15:0]        angle_out,
    input  logic signed [15:0] speed_out,
    input  logic signed [15:0] current_out,
    input  logic [7:0]         temperature_out,
    input  logic signed [23:0] turn_count,
    input  logic signed [36:0] total_angle_out,
    input  logic signed [31:0] filtered_current_q16,
    input  logic [28:0]        power_q16,
    output int                 fail_count,
    output int                 pending_count,
    output int                 frames_seen,
    output int                 tracked_seen
);
    import mft_pkg::*;

    localparam longint TOTAL_MAX = 64'sd68719476735;
    localparam longint TOTAL_MIN = -64'sd68719476736;
    localparam logic signed [23:0] TURNS_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] TURNS_MIN = -24'sh800000;
    localparam logic [63:0] POWER_MAX = 64'd536870911;

    typedef struct {
        logic               tracking;
        logic [15:0]        offset;
        logic [15:0]        angle;
        logic signed [15:0] speed;
        logic signed [15:0] current;
        logic [7:0]         temp;
        logic signed [23:0] turns;
        logic signed [36:0] total;
        logic signed [31:0] filt;
        logic [28:0]        power;
    } frame_result_t;

    frame_result_t expected_frames[$];
    frame_result_t want;

    // Register copies
    logic [7:0]  init_frames_q;
    logic [15:0] alpha_q;
    logic [31:0] coef_q;

    // Tracker state copy
    logic               done_q;
    logic [7:0]         init_count_q;
    logic [15:0]        offset_q;
    logic [15:0]        prev_angle_q;
    logic signed [23:0] turns_q;
    logic signed [31:0] filt_q;

    task automatic unwrap_frame();
        frame_result_t r;
        logic [8:0]  next_count;
        int          diff;
        longint      total;
        longint      acc;
        longint      prod;
        logic [63:0] mag;
        logic [63:0] pw;

        r.tracking = 1'b0;
        r.total    = '0;
        r.power    = '0;
        if (!done_q) begin
            next_count = {1'b0, init_count_q} + 9'd1;
            if (next_count > {1'b0, init_frames_q})
                done_q = 1'b1;
            else
                offset_q = angle_raw;
            init_count_q = (next_count > 9'd255) ? 8'd255 : next_count[7:0];
            prev_angle_q = offset_q;
        end
        else begin
            r.tracking = 1'b1;
            diff = int'(angle_raw) - int'(prev_angle_q);
            if (diff > COUNTS_PER_TURN / 2) begin
                if (turns_q > TURNS_MIN)
                    turns_q = turns_q - 24'sd1;
            end
            else if (diff < -(COUNTS_PER_TURN / 2)) begin
                if (turns_q < TURNS_MAX)
                    turns_q = turns_q + 24'sd1;
            end
            total = longint'(turns_q) * COUNTS_PER_TURN + longint'(angle_raw);
            if (total > TOTAL_MAX)
                total = TOTAL_MAX;
            if (total < TOTAL_MIN)
                total = TOTAL_MIN;
            r.total = total[36:0];
            prev_angle_q = angle_raw;

            // arithmetic shift of a signed value rounds toward minus infinity
            acc = longint'(filt_q) * (65536 - longint'(alpha_q))
                + longint'(current_raw) * longint'(alpha_q) * 65536;
            acc = acc >>> 16;
            if (acc > 64'sd2147483647)
                acc = 64'sd2147483647;
            if (acc < -64'sd2147483648)
                acc = -64'sd2147483648;
            filt_q = acc[31:0];

            prod = longint'(current_raw) * longint'(speed_raw);
            mag  = (prod < 0) ? -prod : prod;
            pw   = (mag * {32'd0, coef_q}) >> 16;
            if (pw > POWER_MAX)
                pw = POWER_MAX;
            r.power = pw[28:0];
        end
        r.offset  = offset_q;
        r.angle   = angle_raw;
        r.speed   = speed_raw;
        r.current = current_raw;
        r.temp    = temperature_raw;
        r.turns   = turns_q;
        r.filt    = filt_q;
        expected_frames.push_back(r);
    endtask

    task automatic check_field(input string field, input logic signed [63:0] exp_v,
                               input logic signed [63:0] act_v);
        if (act_v !== exp_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            init_frames_q = INIT_FRAMES_RST;
            alpha_q       = LPF_ALPHA_RST;
            coef_q        = POWER_COEF_RST;
            done_q        = 1'b0;
            init_count_q  = '0;
            offset_q      = '0;
            prev_angle_q  = '0;
            turns_q       = '0;
            filt_q        = '0;
            expected_frames.delete();
            fail_count    = 0;
            pending_count = 0;
            frames_seen   = 0;
            tracked_seen  = 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_INIT_FRAMES: init_frames_q = pwdata[7:0];
                    REG_LPF_ALPHA:   alpha_q       = pwdata[15:0];
                    REG_POWER_COEF:  coef_q        = pwdata;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                unwrap_frame();
            if (out_valid && out_ready) begin
                frames_seen++;
                if (expected_frames.size() == 0) begin
                    fail_count++;
                    $display("%0t: result transfer with no frame outstanding", $time);
                end
                else begin
                    want = expected_frames.pop_front();
                    if (want.tracking)
                        tracked_seen++;
                    check_field("tracking", want.tracking, tracking);
                    check_field("offset_out", want.offset, offset_out);
                    check_field("angle_out", want.angle, angle_out);
                    check_field("speed_out", want.speed, speed_out);
                    check_field("current_out", want.current, current_out);
                    check_field("temperature_out", want.temp, temperature_out);
                    check_field("turn_count", want.turns, turn_count);
                    check_field("total_angle_out", want.total, total_angle_out);
                    check_field("filtered_current_q16", want.filt, filtered_current_q16);
                    check_field("power_q16", want.power, power_q16);
                end
            end
            pending_count = expected_frames.size();
        end
    end

endmodule

// ===== test/motor_feedback_multiturn_tracker_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_tracker_test
// Drives feedback frames and register writes into the tracker: a full offset
// capture phase with the longest init count, directed wrap and extreme-value
// frames, then random angle walks under several filter and power settings,
// with random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_tracker_test;
    import mft_pkg::*;

    localparam int COUNTS_PER_TURN = 8192;
    localparam int NUM_PHASES      = 6;
    localparam int PHASE_FRAMES    = 225;
    localparam int LONG_HOLD       = 300;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int N_DIRECTED      = 16;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [15:0]        angle_raw;
    logic signed [15:0] speed_raw;
    logic signed [15:0] current_raw;
    logic [7:0]         temperature_raw;
    logic               out_valid;
    logic               out_ready;
    logic               tracking;
    logic [15:0]        offset_out;
    logic [15:0]        angle_out;
    logic signed [15:0] speed_out;
    logic signed [15:0] current_out;
    logic [7:0]         temperature_out;
    logic signed [23:0] turn_count;
    logic signed [36:0] total_angle_out;
    logic signed [31:0] filtered_current_q16;
    logic [28:0]        power_q16;

    int fail_count;
    int pending_count;
    int frames_seen;
    int tracked_seen;
    int reg_writes;
    int cycle_count;

    bit src_idle;
    bit sink_idle;
    bit hold_long;

    motor_feedback_multiturn_tracker #(
        .COUNTS_PER_TURN(COUNTS_PER_TURN)
    ) u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .angle_raw           (angle_raw),
        .speed_raw           (speed_raw),
        .current_raw         (current_raw),
        .temperature_raw     (temperature_raw),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .tracking            (tracking),
        .offset_out          (offset_out),
        .angle_out           (angle_out),
        .speed_out           (speed_out),
        .current_out         (current_out),
        .temperature_out     (temperature_out),
        .turn_count          (turn_count),
        .total_angle_out     (total_angle_out),
        .filtered_current_q16(filtered_current_q16),
        .power_q16           (power_q16)
    );

    motor_feedback_multiturn_tracker_check #(
        .COUNTS_PER_TURN(COUNTS_PER_TURN)
    ) u_check (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .angle_raw           (angle_raw),
        .speed_raw           (speed_raw),
        .current_raw         (current_raw),
        .temperature_raw     (temperature_raw),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .tracking            (tracking),
        .offset_out          (offset_out),
        .angle_out           (angle_out),
        .speed_out           (speed_out),
        .current_out         (current_out),
        .temperature_out     (temperature_out),
        .turn_count          (turn_count),
        .total_angle_out     (total_angle_out),
        .filtered_current_q16(filtered_current_q16),
        .power_q16           (power_q16),
        .fail_count          (fail_count),
        .pending_count       (pending_count),
        .frames_seen         (frames_seen),
        .tracked_seen        (tracked_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_writes++;
        // leave the bus idle before the next setup
        @(posedge clk);
    endtask

    // Offer one frame, hold it until the transfer, then maybe leave a gap.
    task automatic send_frame(input logic [15:0] a, input logic signed [15:0] s,
                              input logic signed [15:0] c, input logic [7:0] t);
        in_valid        <= 1'b1;
        angle_raw       <= a;
        speed_raw       <= s;
        current_raw     <= c;
        temperature_raw <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11))
                @(posedge clk);
        end
    endtask

    // Drop valid and let every outstanding result drain.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return -16'sh8000;
            2:       return 16'sd0;
            3:       return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int held;

        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long) begin
                out_ready <= 1'b0;
                held = 0;
                while (held < LONG_HOLD) begin
                    @(posedge clk);
                    held++;
                end
                out_ready <= 1'b1;
                hold_long = 1'b0;
            end
            else if (sink_idle && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11))
                    @(posedge clk);
                out_ready <= 1'b1;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [15:0]        dir_angle[N_DIRECTED];
        logic signed [15:0] dir_speed[N_DIRECTED];
        logic signed [15:0] dir_cur[N_DIRECTED];
        logic [7:0]         dir_temp[N_DIRECTED];
        logic [15:0]        walk_angle;
        logic [31:0]        coef;
        logic [15:0]        alpha;
        int                 delta;

        // forward step of exactly half a turn is no wrap, one count more is
        dir_angle = '{16'd0, 16'd4096, 16'd8193, 16'd4097, 16'd0, 16'd65535, 16'd0,
                      16'd65535, 16'd65535, 16'd61438, 16'd57342, 16'd61439, 16'd65535,
                      16'd100, 16'd8292, 16'd100};
        dir_speed = '{16'sd0, 16'sd100, -16'sd100, 16'sd1, 16'sd0, 16'sh7FFF, -16'sh8000,
                      -16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1000, 16'sh7FFF,
                      -16'sd5, 16'sd77, 16'sd0};
        dir_cur   = '{16'sd0, 16'sd100, 16'sd50, -16'sd1, 16'sd0, 16'sh7FFF, -16'sh8000,
                      16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, -16'sd300, 16'sh7FFF,
                      16'sd3, -16'sd9, 16'sd0};
        dir_temp  = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd0, 8'd255, 8'd0, 8'd255, 8'd77,
                      8'd200, 8'd5, 8'd0, 8'd255, 8'd64, 8'd32, 8'd16};

        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_valid        <= 1'b0;
        angle_raw       <= '0;
        speed_raw       <= '0;
        current_raw     <= '0;
        temperature_raw <= '0;
        src_idle    = 1'b1;
        sink_idle   = 1'b1;
        hold_long   = 1'b0;
        reg_writes  = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Longest capture phase: the counter tops out and still ends the phase
        write_reg(REG_INIT_FRAMES, 32'd255);
        @(posedge clk);
        repeat (256)
            send_frame(16'($urandom), pick_operand(), pick_operand(), 8'($urandom));

        // Directed tracking frames under the reset filter and power settings
        for (int i = 0; i < N_DIRECTED; i++)
            send_frame(dir_angle[i], dir_speed[i], dir_cur[i], dir_temp[i]);
        drain();

        walk_angle = dir_angle[N_DIRECTED - 1];
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       begin alpha = 16'd0;     coef = 32'hFFFF_FFFF; end
                1:       begin alpha = 16'hFFFF;  coef = 32'd0;         end
                2:       begin alpha = LPF_ALPHA_RST; coef = POWER_COEF_RST; end
                default: begin
                    alpha = 16'($urandom);
                    coef  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 200000)
                                                         : $urandom;
                end
            endcase
            write_reg(REG_LPF_ALPHA, {16'd0, alpha});
            write_reg(REG_POWER_COEF, coef);
            // already tracking, so this only exercises the register
            write_reg(REG_INIT_FRAMES, (p == 0) ? 32'd0 : 32'($urandom_range(0, 255)));
            @(posedge clk);

            src_idle  = (p != NUM_PHASES - 1);
            sink_idle = (p != NUM_PHASES - 1);
            for (int i = 0; i < PHASE_FRAMES; i++) begin
                if (p == 2 && i == 40)
                    hold_long = 1'b1;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: delta = int'($urandom_range(0, 600)) - 300;
                    5, 6, 7:       delta = ($urandom_range(0, 1) ? 1 : -1)
                                           * int'($urandom_range(4090, 4102));
                    default:       delta = int'($urandom_range(0, 65535));
                endcase
                walk_angle = walk_angle + 16'(delta);
                send_frame(walk_angle, pick_operand(), pick_operand(), 8'($urandom));
            end
            drain();
        end

        repeat (20)
            @(posedge clk);
        $display("Covered %0d frames (%0d tracked) through capture, wraps and extremes,",
                 frames_seen, tracked_seen);
        $display("with %0d register writes over %0d filter/power settings.",
                 reg_writes, NUM_PHASES + 1);
        if (fail_count == 0 && pending_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/mft_pkg.sv
sv/mft_ctrl.sv
sv/mft_datapath.sv
sv/motor_feedback_multiturn_tracker.sv
sv/mft_checker.sv
test/motor_feedback_multiturn_tracker_check.sv
test/motor_feedback_multiturn_tracker_test.sv
